// ===== sv/rdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdpt_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 6;
   localparam int MARGIN_W    = 16;
   localparam int MAG_W       = COORD_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd500;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
   } point_type;

   typedef struct packed {
      logic               is_new;
      logic [INDEX_W-1:0] entry_index;
      logic               table_full;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] v);
      logic [CNT_W+INDEX_W-1:0] ext;
      ext = {{INDEX_W{1'b0}}, v};
      return ext[INDEX_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/radius_dedup_point_table.sv =====
// Flow: an accepted req word is compared against the stored entries in index order
// through a registered read, difference and square pipeline; the walk stops at the first
// close entry. A new req word is taken only in idle, after the previous answer is issued;
// a held rsp word delays the next answer until it is taken.
// Reset: synchronous active-high reset empties the table and sets margin to 500;
// table contents are not cleared, only the entry count.
`timescale 1ns / 1ps
`default_nettype none

module radius_dedup_point_table import rdpt_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire point_type           req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output result_type               rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [MARGIN_W-1:0] csr_wr_data
);

   logic [2*COORD_W-1:0] mem [MAX_ENTRIES];

   state_type            state_ff, state_in;
   logic [MARGIN_W-1:0]  margin_ff;
   logic [SQ_W-1:0]      lim_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   point_type            pt_ff;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 issue_en;

   logic                 v1_ff, v2_ff, v3_ff;
   logic [CNT_W-1:0]     idx1_ff, idx2_ff, idx3_ff;
   logic [2*COORD_W-1:0] rd_ff;
   logic [MAG_W-1:0]     dx_ff, dy_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff;
   logic [SQ_W:0]        sq_sum;
   logic                 hit;
   logic                 flush;

   logic                 res_hit_ff, res_hit_in;
   logic [CNT_W-1:0]     res_idx_ff, res_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;
   logic                 wr_en;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign sq_sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit       = v3_ff && (sq_sum < {1'b0, lim_ff});
   assign issue_en  = (state_ff == ST_SCAN) && (issue_ff < count_ff) && !hit;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      flush        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               issue_in   = '0;
               res_hit_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_hit_in = 1'b1;
               res_idx_in = idx3_ff;
               flush      = 1'b1;
               state_in   = ST_FINISH;
            end else if (issue_ff >= count_ff && !v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_FINISH;
            end else if (issue_en) begin
               issue_in = issue_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (res_hit_ff) begin
                  rsp_data_in = '{is_new: 1'b0, entry_index: to_index(res_idx_ff),
                                  table_full: 1'b0};
               end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                  rsp_data_in = '{is_new: 1'b0, entry_index: '0, table_full: 1'b1};
               end else begin
                  rsp_data_in = '{is_new: 1'b1, entry_index: to_index(count_ff),
                                  table_full: 1'b0};
                  wr_en       = 1'b1;
                  count_in    = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory: one write port for append, one registered read for the walk
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= {pt_ff.pos_x, pt_ff.pos_y};
      end
      rd_ff <= mem[issue_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pt_ff <= req_data;
      end
      lim_ff  <= {{MARGIN_W{1'b0}}, margin_ff} * {{MARGIN_W{1'b0}}, margin_ff};
      idx1_ff <= issue_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= abs_diff(pt_ff.pos_x, rd_ff[2*COORD_W-1:COORD_W]);
      dy_ff   <= abs_diff(pt_ff.pos_y, rd_ff[COORD_W-1:0]);
      sqx_ff  <= {{MAG_W{1'b0}}, dx_ff} * {{MAG_W{1'b0}}, dx_ff};
      sqy_ff  <= {{MAG_W{1'b0}}, dy_ff} * {{MAG_W{1'b0}}, dy_ff};
      res_idx_ff  <= res_idx_in;
      rsp_data_ff <= rsp_data_in;
      issue_ff    <= issue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         margin_ff    <= MARGIN_RESET;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         res_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_hit_ff   <= res_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            margin_ff <= csr_wr_data;
         end
         // drop in-flight compares once the first close entry is found
         v1_ff <= issue_en && !flush;
         v2_ff <= v1_ff && !flush;
         v3_ff <= v2_ff && !flush;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
